// File: hdl/trpp_pkg.sv
package trpp_pkg;

    // Input beat actions; the fourth code does nothing.
    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_LINE   = 2'd1,
        ACT_START  = 2'd2
    } action_t;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_BIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FREQ_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_OFFSET = 3'd4;

    // Square root unit: radicand is (2 * d) in Q16.16 scaled by 2^16.
    localparam int RAD_W  = 50;
    localparam int ROOT_W = 25;
    localparam int REM_W  = ROOT_W + 2;
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] SQRT_STEPS = 5'd25;

    typedef struct packed {
        action_t     action;
        logic [31:0] value;
        logic [31:0] upper_edge;
        logic [3:0]  line_slot;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [15:0] peak_bin;
        logic [31:0] frequency;
        logic [31:0] snr;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic mul_start;
        logic add_en;
        logic walk_en;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic run_end;
        logic veto_done;
        logic veto_hit;
        logic root_busy;
    } dp_sts_t;

endpackage

// File: hdl/threshold_run_peak_picker.sv
// Threshold run peak picker.
// Load threshold, first bin, frequency step, line count and noise offset on
// the cfg_* channel (always ready) while the block is idle. On the s_* channel
// send veto lines (action 1) and a spectrum start carrying the base frequency
// (action 2), then one statistic sample per beat (action 0), last on the final.
// A beat that closes a run yields at most one m_* beat: bin, frequency, SNR.
// Samples that close no run never stall the input. A closing sample holds the
// input until the 25-step bit-serial square root, which runs beside the veto
// walk, has settled; a vetoed candidate holds it until the one-entry-a-cycle
// read of the veto table has covered the lines in use.
// The result sits in an output register: a stalled receiver does not block
// input until a second result is ready, which then waits for the first.
// Reset (aresetn low, synchronous) clears the configuration, the run state and
// any pending result; the veto table keeps its contents and must be loaded
// before lines are counted in use.
module threshold_run_peak_picker import trpp_pkg::*; #(
    parameter int MAX_LINES = 16,
    parameter int BIN_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    assign cfg_ready = 1'b1;

    trpp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    trpp_datapath #(
        .MAX_LINES (MAX_LINES),
        .BIN_BITS  (BIN_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_item    (m_item)
    );

    // A result never overwrites one the receiver has not taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("result register overwritten");

    // Candidate work starts only right after a beat that closes a run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mul_start |-> $past(cmd.accept && sts.run_end))
        else $error("candidate started without a closing sample");

    // A result is loaded only once the root has settled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !sts.root_busy)
        else $error("result loaded while root busy");

    // A candidate that passes the veto keeps the input stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.walk_en && sts.veto_done && !sts.veto_hit) |=> !s_ready)
        else $error("input reopened before surviving candidate was emitted");

endmodule

// File: hdl/trpp_sqrt.sv
module trpp_sqrt import trpp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic [ROOT_W-1:0] root,
    output logic              busy
);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] root_next;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic [REM_W-1:0]  rem_shift;
    logic [REM_W-1:0]  trial;

    // One restoring step: bring down two radicand bits and try a one bit.
    always_comb begin
        rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        if (rem_shift >= trial) begin
            rem_next  = rem_shift - trial;
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end else begin
            rem_next  = rem_shift;
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    // Control of the iteration count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= SQRT_STEPS;
        end else if (busy_reg) begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == 1) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Working registers of the root.
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign root = root_reg;
    assign busy = busy_reg;

endmodule

// File: hdl/trpp_datapath.sv
module trpp_datapath import trpp_pkg::*; #(
    parameter int MAX_LINES = 16,
    parameter int BIN_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  in_item_t             s_item,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  ctrl_cmd_t            cmd,
    output dp_sts_t              sts,
    output out_item_t            m_item
);

    localparam int LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CNT_W  = $clog2(MAX_LINES + 1);
    localparam int PROD_W = BIN_BITS + 32;

    // Configuration registers.
    logic [31:0] threshold_reg;
    logic [15:0] first_bin_reg;
    logic [31:0] freq_step_reg;
    logic [4:0]  line_count_reg;
    logic [31:0] noise_offset_reg;

    // Run tracking state.
    logic                in_run_reg;
    logic [31:0]         best_value_reg;
    logic [BIN_BITS-1:0] best_bin_reg;
    logic [BIN_BITS-1:0] bin_counter_reg;
    logic [31:0]         base_freq_reg;

    // Candidate evaluation.
    logic [PROD_W-1:0] product_reg;
    logic [PROD_W:0]   freq_sum;
    logic [31:0]       freq_reg;
    logic [CNT_W-1:0]  walk_idx_reg;
    logic [CNT_W-1:0]  lines_used;
    logic              chk_valid_reg;
    logic              hit_reg;
    logic [63:0]       veto_mem [MAX_LINES];
    logic [63:0]       veto_rd_reg;
    logic              in_range;
    logic              slot_ok;
    logic [31:0]       diff;
    logic [RAD_W-1:0]  radicand;
    logic [ROOT_W-1:0] root;
    logic              root_busy;
    out_item_t         out_item_reg;

    logic [BIN_BITS-1:0] bin_now;
    logic                above;
    logic                at_or_above;
    logic                run_after;
    logic                take_new;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= '0;
            first_bin_reg    <= '0;
            freq_step_reg    <= '0;
            line_count_reg   <= '0;
            noise_offset_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_THRESHOLD:    threshold_reg    <= cfg_data;
                REG_FIRST_BIN:    first_bin_reg    <= cfg_data[15:0];
                REG_FREQ_STEP:    freq_step_reg    <= cfg_data;
                REG_LINE_COUNT:   line_count_reg   <= cfg_data[4:0];
                REG_NOISE_OFFSET: noise_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Run decisions for the sample on the input.
    always_comb begin
        bin_now     = BIN_BITS'(first_bin_reg) + bin_counter_reg;
        above       = s_item.value > threshold_reg;
        at_or_above = s_item.value >= threshold_reg;
        run_after   = in_run_reg ? above : at_or_above;
        take_new    = in_run_reg ? (above && (s_item.value > best_value_reg)) : at_or_above;
    end

    assign sts.run_end = (s_item.action == ACT_SAMPLE) &&
                         ((in_run_reg && !above) || (s_item.last && run_after));

    // Run state update on each accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_run_reg      <= 1'b0;
            best_value_reg  <= '0;
            best_bin_reg    <= '0;
            bin_counter_reg <= '0;
            base_freq_reg   <= '0;
        end else if (cmd.accept) begin
            case (s_item.action)
                ACT_SAMPLE: begin
                    if (take_new) begin
                        best_value_reg <= s_item.value;
                        best_bin_reg   <= bin_now;
                    end
                    in_run_reg      <= run_after && !s_item.last;
                    bin_counter_reg <= s_item.last ? '0 : bin_counter_reg + 1'b1;
                end
                ACT_START: begin
                    base_freq_reg   <= s_item.value;
                    bin_counter_reg <= '0;
                    in_run_reg      <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Frequency: multiply, then add the base and saturate.
    assign freq_sum = (PROD_W+1)'(base_freq_reg) + (PROD_W+1)'(product_reg);

    always_ff @(posedge aclk) begin
        if (cmd.mul_start) begin
            product_reg <= best_bin_reg * freq_step_reg;
        end
        if (cmd.add_en) begin
            freq_reg <= (|freq_sum[PROD_W:32]) ? 32'hFFFF_FFFF : freq_sum[31:0];
        end
    end

    // Veto table, one read a cycle during the walk.
    assign slot_ok = 32'(s_item.line_slot) < MAX_LINES;

    always_ff @(posedge aclk) begin
        if (cmd.accept && (s_item.action == ACT_LINE) && slot_ok) begin
            veto_mem[LINE_W'(s_item.line_slot)] <= {s_item.upper_edge, s_item.value};
        end
        veto_rd_reg <= veto_mem[walk_idx_reg[LINE_W-1:0]];
    end

    assign lines_used = (32'(line_count_reg) > MAX_LINES) ? CNT_W'(MAX_LINES)
                                                           : CNT_W'(line_count_reg);
    assign in_range   = (freq_reg >= veto_rd_reg[31:0]) && (freq_reg <= veto_rd_reg[63:32]);

    // Walk over the lines in use, comparing each entry from the registered read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_idx_reg  <= '0;
            chk_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end else if (cmd.add_en) begin
            walk_idx_reg  <= '0;
            chk_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end else if (cmd.walk_en) begin
            if (walk_idx_reg < lines_used) begin
                walk_idx_reg  <= walk_idx_reg + 1'b1;
                chk_valid_reg <= 1'b1;
            end else begin
                chk_valid_reg <= 1'b0;
            end
            if (chk_valid_reg && in_range) begin
                hit_reg <= 1'b1;
            end
        end
    end

    assign sts.veto_done = (walk_idx_reg >= lines_used) && !chk_valid_reg;
    assign sts.veto_hit  = hit_reg;

    // SNR root of 2 * (peak - offset), clamped at zero.
    assign diff     = (best_value_reg > noise_offset_reg) ? best_value_reg - noise_offset_reg
                                                          : '0;
    assign radicand = {1'b0, diff, 17'b0};

    trpp_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.mul_start),
        .radicand (radicand),
        .root     (root),
        .busy     (root_busy)
    );

    assign sts.root_busy = root_busy;

    // Output register.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_item_reg.peak_bin  <= 16'(best_bin_reg);
            out_item_reg.frequency <= freq_reg;
            out_item_reg.snr       <= 32'(root);
        end
    end

    assign m_item = out_item_reg;

endmodule

// File: hdl/trpp_ctrl.sv
module trpp_ctrl import trpp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  dp_sts_t   sts,
    output ctrl_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_ADD  = 6'b000100,
        ST_VETO = 6'b001000,
        ST_ROOT = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Command decode.
    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        cmd.accept    = s_valid && s_ready;
        cmd.mul_start = (state_reg == ST_MUL);
        cmd.add_en    = (state_reg == ST_ADD);
        cmd.walk_en   = (state_reg == ST_VETO);
        cmd.load_out  = (state_reg == ST_EMIT) && out_free;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.accept && sts.run_end) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_VETO;
            ST_VETO: begin
                if (sts.veto_done) begin
                    state_next = sts.veto_hit ? ST_IDLE : ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (!sts.root_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result beat valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: tb/threshold_run_peak_picker_tb.sv
module threshold_run_peak_picker_tb;
    import trpp_pkg::*;

    localparam int VETO_DEPTH = 16;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 64;
    localparam action_t ACT_NONE = action_t'(2'd3);

    // Predicts the candidate beats that the peak picker emits and checks them in order.
    class peak_predictor;
        bit [31:0] thr;
        bit [15:0] first;
        bit [31:0] step;
        bit [4:0]  nlines;
        bit [31:0] noise;

        bit        in_run;
        bit [31:0] best_val;
        bit [15:0] best_bin;
        bit [15:0] bin_cnt;
        bit [31:0] base;
        bit [63:0] veto_rows [VETO_DEPTH];

        out_item_t expected_peaks [$];
        int        errors;
        int        n_peaks;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] data);
            case (idx)
                REG_THRESHOLD:    thr = data;
                REG_FIRST_BIN:    first = data[15:0];
                REG_FREQ_STEP:    step = data;
                REG_LINE_COUNT:   nlines = data[4:0];
                REG_NOISE_OFFSET: noise = data;
                default: ;
            endcase
        endfunction

        // Largest r with r*r <= v, built one bit at a time from the top.
        function bit [31:0] root_floor(bit [63:0] v);
            bit [63:0] r;
            bit [63:0] cand;
            r = '0;
            for (int b = 24; b >= 0; b--) begin
                cand = r | (64'd1 << b);
                if (cand * cand <= v) r = cand;
            end
            return r[31:0];
        endfunction

        // Close the current run and queue a candidate unless its frequency is vetoed.
        function void close_run();
            bit [63:0] full;
            bit [31:0] freq;
            bit [31:0] d;
            int        n;
            out_item_t peak;
            in_run = 1'b0;
            full = 64'(base) + 64'(best_bin) * 64'(step);
            freq = (full > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : full[31:0];
            n = (nlines > VETO_DEPTH) ? VETO_DEPTH : int'(nlines);
            for (int k = 0; k < n; k++) begin
                if (freq >= veto_rows[k][31:0] && freq <= veto_rows[k][63:32]) return;
            end
            peak.peak_bin = best_bin;
            peak.frequency = freq;
            peak.snr = '0;
            if (best_val > noise) begin
                d = best_val - noise;
                peak.snr = root_floor(64'(d) << 17);
            end
            expected_peaks.push_back(peak);
        endfunction

        function void note_beat(in_item_t it);
            bit [15:0] bin;
            case (it.action)
                ACT_LINE: begin
                    veto_rows[it.line_slot] = {it.upper_edge, it.value};
                end
                ACT_START: begin
                    base = it.value;
                    bin_cnt = '0;
                    in_run = 1'b0;
                end
                ACT_SAMPLE: begin
                    bin = first + bin_cnt;
                    if (!in_run) begin
                        if (it.value >= thr) begin
                            in_run = 1'b1;
                            best_val = it.value;
                            best_bin = bin;
                        end
                    end else if (it.value > thr) begin
                        if (it.value > best_val) begin
                            best_val = it.value;
                            best_bin = bin;
                        end
                    end else begin
                        close_run();
                    end
                    if (it.last) begin
                        if (in_run) close_run();
                        in_run = 1'b0;
                        bin_cnt = '0;
                    end else begin
                        bin_cnt = bin_cnt + 16'd1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_peak(out_item_t got);
            out_item_t want;
            if (expected_peaks.size() == 0) begin
                $error("unexpected result beat: peak_bin %0h frequency %0h snr %0h",
                       got.peak_bin, got.frequency, got.snr);
                errors++;
                return;
            end
            want = expected_peaks.pop_front();
            n_peaks++;
            if (got.peak_bin !== want.peak_bin) begin
                $error("peak_bin: expected %0h, got %0h", want.peak_bin, got.peak_bin);
                errors++;
            end
            if (got.frequency !== want.frequency) begin
                $error("frequency: expected %0h, got %0h", want.frequency, got.frequency);
                errors++;
            end
            if (got.snr !== want.snr) begin
                $error("snr: expected %0h, got %0h", want.snr, got.snr);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    in_item_t             s_item = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_item_t            m_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    peak_predictor pred = new();

    int items_sent;
    int burst_left;
    bit sender_gaps = 1'b1;
    bit recv_stalls = 1'b1;
    int ready_run;
    int stall_run;
    int quiet_cycles;

    threshold_run_peak_picker #(
        .MAX_LINES(VETO_DEPTH),
        .BIN_BITS (16)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Result side: check each accepted beat and, when stalls are on, stall in runs of random length.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) pred.check_peak(m_item);
        if (!recv_stalls) begin
            m_ready <= 1'b1;
        end else if (stall_run > 0) begin
            stall_run--;
            m_ready <= 1'b0;
        end else if (ready_run > 0) begin
            ready_run--;
            m_ready <= 1'b1;
        end else begin
            ready_run = $urandom_range(1, 10);
            stall_run = $urandom_range(0, 12);
            m_ready <= 1'b1;
        end
    end

    // Watchdog: give up when no channel has moved a beat for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("threshold_run_peak_picker_tb: done, errors");
            $finish;
        end
    end

    function automatic in_item_t mk_beat(action_t a, bit [31:0] v, bit [31:0] up,
                                         bit [3:0] slot, bit lst);
        in_item_t it;
        it.action = a;
        it.value = v;
        it.upper_edge = up;
        it.line_slot = slot;
        it.last = lst;
        return it;
    endfunction

    // Sample value around the threshold so that runs start, grow and end.
    function automatic bit [31:0] pick_sample(bit [31:0] thr);
        bit [32:0] sum;
        case ($urandom_range(0, 9))
            0, 1: return thr;
            2, 3, 4, 5: begin
                sum = 33'(thr) + 33'($urandom_range(1, 32'h0004_0000));
                return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
            6, 7: return (thr > 32'h0004_0000) ? thr - $urandom_range(1, 32'h0004_0000)
                                               : $urandom_range(0, thr);
            8: return $urandom;
            default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        endcase
    endfunction

    // One input beat: bursts of random length, separated by random gaps when gaps are on.
    task automatic send_beat(in_item_t it);
        int gap;
        if (burst_left == 0) begin
            if (sender_gaps) begin
                gap = $urandom_range(1, 6);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_item <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        pred.note_beat(it);
        if (it.action != ACT_NONE) items_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [31:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        pred.set_reg(idx, data);
    endtask

    task automatic apply_settings(bit [31:0] thr, bit [15:0] first, bit [31:0] step,
                                  bit [4:0] nlines, bit [31:0] noise);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_FIRST_BIN, 32'(first));
        write_reg(REG_FREQ_STEP, step);
        write_reg(REG_LINE_COUNT, 32'(nlines));
        write_reg(REG_NOISE_OFFSET, noise);
        cfg_valid <= 1'b0;
    endtask

    // Wait for every candidate, then for the back part to finish a vetoed one.
    task automatic settle();
        s_valid <= 1'b0;
        while (pred.expected_peaks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Veto line either near the current spectrum's frequencies or anywhere.
    task automatic send_line(bit [3:0] slot);
        bit [31:0] lo;
        bit [31:0] hi;
        if ($urandom_range(0, 1)) begin
            lo = pred.base + $urandom_range(0, 30) * pred.step;
            hi = lo + $urandom_range(0, 2) * pred.step + $urandom_range(0, 255);
        end else begin
            lo = $urandom;
            hi = lo + $urandom_range(0, 32'h0100_0000);
        end
        send_beat(mk_beat(ACT_LINE, lo, hi, slot, 1'($urandom)));
    endtask

    // Random stream: mostly whole spectra, some line updates, some noise.
    task automatic run_stream(int quota);
        int        start_count;
        int        len;
        bit        drop_last;
        bit        lst;
        bit [31:0] base;
        start_count = items_sent;
        while (items_sent - start_count < quota) begin
            case ($urandom_range(0, 99)) inside
                [0:7]: send_line(4'($urandom));
                [8:10]: begin
                    if ($urandom_range(0, 1))
                        send_beat(mk_beat(ACT_NONE, $urandom, $urandom, 4'($urandom),
                                          1'($urandom)));
                    else
                        send_beat(mk_beat(ACT_SAMPLE, $urandom, $urandom, 4'($urandom),
                                          1'($urandom)));
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: base = $urandom_range(0, 32'h000F_FFFF);
                        1: base = 32'hFFFF_FFFF - $urandom_range(0, 32'h00FF_FFFF);
                        default: base = $urandom;
                    endcase
                    if ($urandom_range(0, 19) != 0)
                        send_beat(mk_beat(ACT_START, base, $urandom, 4'($urandom),
                                          1'($urandom)));
                    len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 90)
                                                       : $urandom_range(1, 20);
                    drop_last = ($urandom_range(0, 9) == 0);
                    for (int i = 0; i < len; i++) begin
                        if ($urandom_range(0, 32) == 0) send_line(4'($urandom));
                        lst = (i == len - 1 && !drop_last) || ($urandom_range(0, 49) == 0);
                        send_beat(mk_beat(ACT_SAMPLE, pick_sample(pred.thr), $urandom,
                                          4'($urandom), lst));
                    end
                end
            endcase
        end
    endtask

    initial begin
        int p;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: wrap of the bin index, saturated frequency, no veto lines in use.
        apply_settings(32'h0005_0000, 16'hFFFE, 32'h1000_0000, 5'd0, 32'h0006_0000);
        send_beat(mk_beat(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 1'b1));
        send_beat(mk_beat(ACT_LINE, 32'hFFFF_FFFF, 32'h0, 4'hF, 1'b0));
        send_beat(mk_beat(ACT_LINE, 32'h0, 32'hFFFF_FFFF, 4'h0, 1'b1));
        send_beat(mk_beat(ACT_START, 32'h0000_1000, 32'h0, 4'h0, 1'b0));
        // Run opens at the threshold, keeps the first of two equal maxima,
        // and closes on a sample equal to the threshold.
        send_beat(mk_beat(ACT_SAMPLE, 32'h0005_0000, 32'h0, 4'h0, 1'b0));
        send_beat(mk_beat(ACT_SAMPLE, 32'h0009_0000, 32'h0, 4'h0, 1'b0));
        send_beat(mk_beat(ACT_SAMPLE, 32'h0009_0000, 32'h0, 4'h0, 1'b0));
        send_beat(mk_beat(ACT_SAMPLE, 32'h0005_0000, 32'h0, 4'h0, 1'b0));
        send_beat(mk_beat(ACT_SAMPLE, 32'h0007_0000, 32'h0, 4'h0, 1'b0));
        send_beat(mk_beat(ACT_SAMPLE, 32'h0000_0000, 32'h0, 4'h0, 1'b0));
        // Peak below the noise offset gives a zero SNR.
        send_beat(mk_beat(ACT_SAMPLE, 32'h0005_5000, 32'h0, 4'h0, 1'b0));
        send_beat(mk_beat(ACT_SAMPLE, 32'h0004_0000, 32'h0, 4'h0, 1'b0));
        // Run closed by the last sample, then a run dropped by a new spectrum start.
        send_beat(mk_beat(ACT_SAMPLE, 32'h0006_0000, 32'h0, 4'h0, 1'b0));
        send_beat(mk_beat(ACT_SAMPLE, 32'hFFFF_FFFF, 32'h0, 4'h0, 1'b1));
        send_beat(mk_beat(ACT_SAMPLE, 32'h0008_0000, 32'h0, 4'h0, 1'b0));
        send_beat(mk_beat(ACT_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 1'b1));
        send_beat(mk_beat(ACT_SAMPLE, 32'hFFFF_FFFF, 32'h0, 4'h0, 1'b1));
        send_beat(mk_beat(ACT_SAMPLE, 32'h0001_0000, 32'h0, 4'h0, 1'b1));
        // Line write and unknown action inside a run, closed by a low last sample.
        send_beat(mk_beat(ACT_SAMPLE, 32'h0008_0000, 32'h0, 4'h0, 1'b0));
        send_beat(mk_beat(ACT_LINE, 32'h1234_5678, 32'h2345_6789, 4'h7, 1'b0));
        send_beat(mk_beat(ACT_NONE, 32'h0, 32'h0, 4'h0, 1'b0));
        send_beat(mk_beat(ACT_SAMPLE, 32'h0000_0000, 32'h0, 4'h0, 1'b1));

        // Fill every veto entry before any line count puts one in use.
        for (int k = 0; k < VETO_DEPTH; k++) send_line(4'(k));

        p = 1;
        while (p < 6 || (pred.n_peaks < 48 && p < 12)) begin
            sender_gaps = (p % 3 != 1);
            recv_stalls = (p % 3 != 2);
            settle();
            case (p)
                1: apply_settings(32'h0001_0000, 16'h0, 32'h0000_0100, 5'd16, 32'h0);
                2: apply_settings(32'h0, 16'hFFF0, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
                3: apply_settings(32'hFFFF_FFFF, 16'hFFFF, 32'h0, 5'd0, 32'h0000_8000);
                default: apply_settings($urandom_range(0, 1) ? $urandom
                                                             : $urandom_range(0, 32'h0010_0000),
                                        16'($urandom), $urandom_range(0, 1) ? $urandom
                                        : $urandom_range(0, 32'h0010_0000),
                                        5'($urandom_range(0, 31)),
                                        $urandom_range(0, 32'h0008_0000));
            endcase
            if (p == 1) begin
                // Veto edges are inclusive: bins 0 and 2 hit the edges, bin 4 passes.
                send_beat(mk_beat(ACT_LINE, 32'h4000_0000, 32'h4000_0200, 4'h0, 1'b0));
                send_beat(mk_beat(ACT_START, 32'h4000_0000, 32'h0, 4'h0, 1'b0));
                send_beat(mk_beat(ACT_SAMPLE, 32'h0002_0000, 32'h0, 4'h0, 1'b0));
                send_beat(mk_beat(ACT_SAMPLE, 32'h0, 32'h0, 4'h0, 1'b0));
                send_beat(mk_beat(ACT_SAMPLE, 32'h0002_0000, 32'h0, 4'h0, 1'b0));
                send_beat(mk_beat(ACT_SAMPLE, 32'h0, 32'h0, 4'h0, 1'b0));
                send_beat(mk_beat(ACT_SAMPLE, 32'h0002_0000, 32'h0, 4'h0, 1'b0));
                send_beat(mk_beat(ACT_SAMPLE, 32'h0, 32'h0, 4'h0, 1'b1));
            end
            run_stream(300);
            p++;
        end

        settle();
        if (pred.errors == 0 && pred.expected_peaks.size() == 0)
            $display("threshold_run_peak_picker_tb: done, clean");
        else
            $display("threshold_run_peak_picker_tb: done, errors");
        $finish;
    end

endmodule
